>>> design/bsst_pkg.sv
// shared types, constants and helpers for the bounded set span tracker
// no dependencies

package bsst_pkg;

    localparam int unsigned CNT_W    = 11;
    localparam int unsigned VAL_W    = 32;
    localparam int unsigned GAP_W    = 33;
    localparam int unsigned IN_DW    = 40;
    localparam int unsigned OUT_DW   = 80;

    localparam logic [VAL_W-1:0] SIGN_BIAS      = 32'h8000_0000;
    localparam logic [GAP_W-1:0] GAP_ALL_ONES   = {GAP_W{1'b1}};
    localparam logic [CNT_W-1:0] MAX_SIZE_RESET = 11'd10;

    // control from the sequencer to the gap unit
    typedef struct packed {
        logic clear;   // return the smallest gap to all ones
        logic sample;  // a stored word is on the read data bus
    } t_gap_ctrl;

    function automatic logic [VAL_W-1:0] abs_diff(input logic [VAL_W-1:0] a,
                                                   input logic [VAL_W-1:0] b);
        return (a > b) ? (a - b) : (b - a);
    endfunction

endpackage

>>> design/bounded_set_span_tracker.sv
// bounded set span tracker: one result word per input word, sequential; uses bsst_pkg, bsst_gap_unit
// a new word is taken only in idle, once the last one is through; a dropped word on a full set
//   skips the sweep, any other word waits for the single read port of the value memory,
//   swept once per word for the smallest gap
// reset (synchronous, active low) empties the set and sets max_size to 10;
//   the value memory is not cleared, only entries below the count are ever read

module bounded_set_span_tracker
    import bsst_pkg::*;
#(
    parameter int unsigned CAPACITY = 1024
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // configuration: max_size
    input  logic              i_cfg_we,
    input  logic [CNT_W-1:0]  i_cfg_wdata,
    // input words
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [IN_DW-1:0]  s_axis_tdata,   // value[31:0], restart[32], zero pad
    // result words
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [OUT_DW-1:0] m_axis_tdata    // status[0], count[11:1], span_valid[12],
                                              // longest_span[44:13], shortest_span[76:45]
);

    localparam int unsigned AW       = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    // max_size is 11 bits wide, at most 2047, so a larger capacity only clips at 2047
    localparam int unsigned CAP_CLIP = (CAPACITY > 2047) ? 2047 : CAPACITY;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_FIN  = 2'd2;
    localparam logic [1:0] ST_OUT  = 2'd3;

    // value memory, held with the sign bit flipped so unsigned order is signed order
    logic [VAL_W-1:0] mem [CAPACITY];
    logic [VAL_W-1:0] mem_q;

    logic [1:0]       r_state;
    logic [CNT_W-1:0] r_max_size;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] r_idx;
    logic             r_rd_vld;
    logic             r_full;
    logic [VAL_W-1:0] r_word;
    logic [VAL_W-1:0] r_max;
    logic [VAL_W-1:0] r_min;
    logic             r_out_vld;
    logic [OUT_DW-1:0] r_out_data;
    logic [OUT_DW-1:0] n_out_data;

    logic [CNT_W-1:0] limit;
    logic [CNT_W-1:0] start_count;
    logic             in_acc;
    logic             rd_en;
    logic             mem_we;
    logic             out_free;
    logic             restart;
    logic [GAP_W-1:0] gap;
    logic             gap_busy;
    t_gap_ctrl        gap_ctrl;

    assign restart     = s_axis_tdata[VAL_W];
    assign limit       = (r_max_size < CNT_W'(CAP_CLIP)) ? r_max_size : CNT_W'(CAP_CLIP);
    assign in_acc      = s_axis_tvalid && s_axis_tready;
    // count as seen by this word, after an optional restart
    assign start_count = restart ? '0 : r_count;

    // one read per cycle while sweeping the held entries
    assign rd_en  = (r_state == ST_SCAN) && (r_idx != r_count);
    assign mem_we = (r_state == ST_FIN);

    assign out_free = !r_out_vld || m_axis_tready;

    assign gap_ctrl.clear  = in_acc && restart;
    assign gap_ctrl.sample = r_rd_vld;

    bsst_gap_unit u_gap (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_ctrl        (gap_ctrl),
        .i_new_word    (r_word),
        .i_stored_word (mem_q),
        .o_gap         (gap),
        .o_busy        (gap_busy)
    );

    // memory ports: one synchronous read, one write
    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            mem_q <= mem[AW'(r_idx)];
        end
        if (mem_we) begin
            mem[AW'(r_count)] <= r_word;
        end
    end

    // configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_size <= MAX_SIZE_RESET;
        end else if (i_cfg_we) begin
            r_max_size <= i_cfg_wdata;
        end
    end

    // payload of the word in work
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_word <= s_axis_tdata[VAL_W-1:0] ^ SIGN_BIAS;
        end
    end

    // sequencer and set state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_count  <= '0;
            r_idx    <= '0;
            r_rd_vld <= 1'b0;
            r_full   <= 1'b0;
            r_max    <= SIGN_BIAS;
            r_min    <= SIGN_BIAS;
        end else begin
            r_rd_vld <= rd_en;
            unique case (r_state)
                ST_IDLE: begin
                    if (in_acc) begin
                        r_idx   <= '0;
                        r_count <= start_count;
                        if (restart) begin
                            r_max <= SIGN_BIAS;
                            r_min <= SIGN_BIAS;
                        end
                        // full words skip the sweep and just report
                        r_full  <= (start_count >= limit);
                        r_state <= (start_count >= limit) ? ST_OUT : ST_SCAN;
                    end
                end
                ST_SCAN: begin
                    if (rd_en) begin
                        r_idx <= r_idx + 1'b1;
                    end else if (!r_rd_vld && !gap_busy) begin
                        r_state <= ST_FIN;
                    end
                end
                ST_FIN: begin
                    // store the new word and fold it into max and min
                    if (r_count == '0) begin
                        r_max <= r_word;
                        r_min <= r_word;
                    end else begin
                        if (r_word > r_max) r_max <= r_word;
                        if (r_word < r_min) r_min <= r_word;
                    end
                    r_count <= r_count + 1'b1;
                    r_state <= ST_OUT;
                end
                ST_OUT: begin
                    if (out_free) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    // output register: lets the next word in while a result waits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if ((r_state == ST_OUT) && out_free) begin
            r_out_vld <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_vld <= 1'b0;
        end
    end

    // result word, spans only once two values are held
    always_comb begin
        n_out_data        = '0;
        n_out_data[0]     = r_full;
        n_out_data[11:1]  = r_count;
        if (r_count >= CNT_W'(2)) begin
            n_out_data[12]    = 1'b1;
            n_out_data[44:13] = r_max - r_min;
            n_out_data[76:45] = gap[VAL_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == ST_OUT) && out_free) begin
            r_out_data <= n_out_data;
        end
    end

    assign s_axis_tready = (r_state == ST_IDLE);
    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = r_out_data;

    // the set never grows past the clipped capacity
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(CAP_CLIP))
        else $error("held count beyond capacity");

    // a new word is stored only after every held entry was read and compared
    a_sweep_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_we |-> (r_idx == r_count) && !r_rd_vld && !gap_busy)
        else $error("store before sweep finished");

    // nothing from the sweep is left in flight when a new word may enter
    a_idle_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> !r_rd_vld && !gap_busy)
        else $error("sweep still active in idle");

endmodule

>>> design/bsst_gap_unit.sv
// smallest pairwise gap: registered distance, then running minimum
// depends on bsst_pkg

module bsst_gap_unit
    import bsst_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_gap_ctrl        i_ctrl,
    input  logic [VAL_W-1:0] i_new_word,
    input  logic [VAL_W-1:0] i_stored_word,
    output logic [GAP_W-1:0] o_gap,
    output logic             o_busy
);

    logic [VAL_W-1:0] r_dist;
    logic             r_dist_vld;
    logic [GAP_W-1:0] r_gap;

    always_ff @(posedge i_clk) begin
        r_dist <= abs_diff(i_new_word, i_stored_word);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dist_vld <= 1'b0;
            r_gap      <= GAP_ALL_ONES;
        end else begin
            r_dist_vld <= i_ctrl.sample;
            if (i_ctrl.clear) begin
                r_gap <= GAP_ALL_ONES;
            end else if (r_dist_vld && ({1'b0, r_dist} < r_gap)) begin
                r_gap <= {1'b0, r_dist};
            end
        end
    end

    assign o_gap  = r_gap;
    assign o_busy = r_dist_vld;

endmodule

>>> bench/testbench.sv
// testbench for the bounded set span tracker: directed table, then random phases
// depends on bsst_pkg and bounded_set_span_tracker from the design folder

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import bsst_pkg::*;

    localparam int unsigned CAPACITY   = 1024;
    localparam int unsigned HALF_CLK   = 2;
    localparam int unsigned DIRECTED_N = 22;

    // one result word, fields as the block reports them
    typedef struct packed {
        logic             status;
        logic [CNT_W-1:0] count;
        logic             span_valid;
        logic [VAL_W-1:0] longest;
        logic [VAL_W-1:0] shortest;
    } t_span_report;

    // one row of the directed table; typed rows carry their own expected word
    typedef struct packed {
        logic             restart;
        logic [VAL_W-1:0] value;
        logic             typed;
        t_span_report     want;
    } t_stim_row;

    logic              i_clk         = 1'b0;
    logic              i_rst_n       = 1'b0;
    logic              i_cfg_we      = 1'b0;
    logic [CNT_W-1:0]  i_cfg_wdata   = '0;
    logic              s_axis_tvalid = 1'b0;
    logic              s_axis_tready;
    logic [IN_DW-1:0]  s_axis_tdata  = '0;   // value[31:0], restart[32], zero pad
    logic              m_axis_tvalid;
    logic              m_axis_tready = 1'b0;
    logic [OUT_DW-1:0] m_axis_tdata;         // status[0], count[11:1], span_valid[12],
                                             // longest_span[44:13], shortest_span[76:45]

    // shadow of the set as the block should hold it, values kept sign-flipped
    logic [VAL_W-1:0] held_vals [CAPACITY];
    int unsigned      held_total;
    logic [VAL_W-1:0] top_val;
    logic [VAL_W-1:0] bottom_val;
    logic [GAP_W-1:0] min_gap;
    logic [CNT_W-1:0] size_limit;

    t_span_report pending_reports [$];
    t_stim_row    directed_rows [DIRECTED_N];

    // sender pacing and receiver stall pattern
    int unsigned      burst_left   = 0;
    logic [VAL_W-1:0] last_value   = '0;
    logic [15:0]      ready_pattern = 16'hFFFF;
    logic [3:0]       ready_phase   = '0;

    // run statistics
    int unsigned mismatch_count = 0;
    int unsigned words_sent     = 0;
    int unsigned words_checked  = 0;
    int unsigned drops_seen     = 0;
    int unsigned largest_count  = 0;

    bounded_set_span_tracker #(
        .CAPACITY (CAPACITY)
    ) u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #HALF_CLK i_clk = ~i_clk;

    // receiver walks a 16-bit ready pattern with bit 0 set, so every pass gives a ready
    always @(negedge i_clk) begin
        ready_phase   <= ready_phase + 4'd1;
        m_axis_tready <= ready_pattern[ready_phase];
    end

    // ---------------------------------------------------------------- predictor

    // empty set: also what a restart does before handling its value
    function automatic void empty_set();
        held_total = 0;
        top_val    = SIGN_BIAS;
        bottom_val = SIGN_BIAS;
        min_gap    = GAP_ALL_ONES;
    endfunction

    // span report after adding one value; updates the shadow set
    function automatic t_span_report predict_spans(input logic restart,
                                                   input logic [VAL_W-1:0] value);
        logic [VAL_W-1:0] flipped;
        logic [VAL_W-1:0] diff;
        int unsigned      eff_limit;
        t_span_report     rep;
        flipped   = value ^ SIGN_BIAS;
        eff_limit = (int'(size_limit) < CAPACITY) ? int'(size_limit) : CAPACITY;
        rep       = '0;
        if (restart) begin
            empty_set();
        end
        if (held_total >= eff_limit) begin
            // full set, or limit lowered below what is already held
            rep.status = 1'b1;
        end else begin
            for (int i = 0; i < held_total; i++) begin
                diff = (flipped > held_vals[i]) ? flipped - held_vals[i]
                                                : held_vals[i] - flipped;
                if ({1'b0, diff} < min_gap) begin
                    min_gap = {1'b0, diff};
                end
            end
            if (held_total == 0) begin
                top_val    = flipped;
                bottom_val = flipped;
            end else begin
                if (flipped > top_val) begin
                    top_val = flipped;
                end
                if (flipped < bottom_val) begin
                    bottom_val = flipped;
                end
            end
            held_vals[held_total] = flipped;
            held_total++;
        end
        rep.count = held_total[CNT_W-1:0];
        if (held_total >= 2) begin
            rep.span_valid = 1'b1;
            rep.longest    = top_val - bottom_val;   // exact, sign bias cancels
            rep.shortest   = min_gap[VAL_W-1:0];
        end
        return rep;
    endfunction

    // ---------------------------------------------------------------- checker

    task automatic note_mismatch(input string what, input logic [79:0] want,
                                 input logic [79:0] got);
        mismatch_count++;
        if (mismatch_count <= 10) begin
            $display("mismatch on %s at %0t: expected %0h, got %0h", what, $realtime,
                     want, got);
        end
    endtask

    // compare each accepted result word with the oldest expected report
    always @(posedge i_clk) begin
        t_span_report got;
        t_span_report want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.status     = m_axis_tdata[0];
            got.count      = m_axis_tdata[11:1];
            got.span_valid = m_axis_tdata[12];
            got.longest    = m_axis_tdata[44:13];
            got.shortest   = m_axis_tdata[76:45];
            if (pending_reports.size() == 0) begin
                note_mismatch("unexpected result word", '0, m_axis_tdata);
            end else begin
                want = pending_reports.pop_front();
                if (got.status !== want.status)
                    note_mismatch("status", want.status, got.status);
                if (got.count !== want.count)
                    note_mismatch("count", want.count, got.count);
                if (got.span_valid !== want.span_valid)
                    note_mismatch("span_valid", want.span_valid, got.span_valid);
                if (got.longest !== want.longest)
                    note_mismatch("longest_span", want.longest, got.longest);
                if (got.shortest !== want.shortest)
                    note_mismatch("shortest_span", want.shortest, got.shortest);
            end
            words_checked++;
            if (got.status === 1'b1) begin
                drops_seen++;
            end
            if (int'(got.count) > largest_count) begin
                largest_count = int'(got.count);
            end
        end
    end

    // ---------------------------------------------------------------- stimulus

    function automatic t_stim_row make_row(input logic r, input logic [VAL_W-1:0] v,
                                           input logic t, input logic st,
                                           input logic [CNT_W-1:0] cnt, input logic sv,
                                           input logic [VAL_W-1:0] lo,
                                           input logic [VAL_W-1:0] sh);
        t_stim_row row;
        row.restart         = r;
        row.value           = v;
        row.typed           = t;
        row.want.status     = st;
        row.want.count      = cnt;
        row.want.span_valid = sv;
        row.want.longest    = lo;
        row.want.shortest   = sh;
        return row;
    endfunction

    // mix of wide random, near-duplicate, extreme and clustered values
    function automatic logic [VAL_W-1:0] pick_value();
        logic [VAL_W-1:0] v;
        case ($urandom_range(0, 9)) inside
            [0:3]: v = $urandom;
            [4:5]: v = last_value + $urandom_range(0, 6) - 3;
            6: begin
                case ($urandom_range(0, 4))
                    0:       v = 32'h8000_0000;
                    1:       v = 32'h7FFF_FFFF;
                    2:       v = 32'h0000_0000;
                    3:       v = 32'hFFFF_FFFF;
                    default: v = 32'h0000_0001;
                endcase
            end
            default:    v = $urandom_range(0, 400) - 200;
        endcase
        last_value = v;
        return v;
    endfunction

    task automatic drop_valid();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
    endtask

    // bursts of random length with random gaps; gap_max 0 means no idling
    task automatic pace_sender(input int unsigned gap_max);
        int unsigned gap;
        if (gap_max != 0) begin
            if (burst_left == 0) begin
                gap = $urandom_range(1, gap_max);
                drop_valid();
                repeat (gap - 1) @(negedge i_clk);
                burst_left = $urandom_range(1, 12);
            end
            burst_left--;
        end
    endtask

    // present one word, wait for the handshake, then queue what it should produce
    task automatic send_word(input logic restart, input logic [VAL_W-1:0] value,
                             input logic typed, input t_span_report want);
        t_span_report predicted;
        @(negedge i_clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {7'b0, restart, value};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        predicted = predict_spans(restart, value);
        pending_reports.insert(pending_reports.size(), typed ? want : predicted);
        words_sent++;
    endtask

    // register write only once the block has answered every word
    task automatic write_max_size(input logic [CNT_W-1:0] limit);
        drop_valid();
        while (pending_reports.size() != 0) @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= limit;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        size_limit = limit;
    endtask

    // restart_odds: 1 in n words restarts (0 never); hold_cap forces a restart
    // once the set reaches that size, which keeps the sweep per word short
    task automatic run_phase(input logic [CNT_W-1:0] limit, input int unsigned words,
                             input int unsigned restart_odds,
                             input int unsigned hold_cap, input int unsigned gap_max,
                             input logic [15:0] ready_bits);
        logic restart;
        write_max_size(limit);
        ready_pattern = ready_bits | 16'h0001;
        for (int n = 0; n < words; n++) begin
            restart = (restart_odds != 0 && $urandom_range(1, restart_odds) == 1)
                   || (hold_cap != 0 && held_total >= hold_cap);
            pace_sender(gap_max);
            send_word(restart, pick_value(), 1'b0, '0);
        end
    endtask

    initial begin
        // directed table, run under the reset limit of ten values
        directed_rows = '{
            // first value alone: no spans yet
            make_row(1'b0, 32'h0000_0005, 1'b1, 1'b0, 11'd1, 1'b0, 32'h0, 32'h0),
            // duplicate gives a zero shortest span
            make_row(1'b0, 32'h0000_0005, 1'b1, 1'b0, 11'd2, 1'b1, 32'h0, 32'h0),
            // most negative value
            make_row(1'b0, 32'h8000_0000, 1'b1, 1'b0, 11'd3, 1'b1, 32'h8000_0005, 32'h0),
            // full signed range: longest span all ones, no overflow
            make_row(1'b0, 32'h7FFF_FFFF, 1'b1, 1'b0, 11'd4, 1'b1, 32'hFFFF_FFFF, 32'h0),
            // restart then a fresh pair around zero
            make_row(1'b1, 32'h0000_0000, 1'b1, 1'b0, 11'd1, 1'b0, 32'h0, 32'h0),
            make_row(1'b0, 32'hFFFF_FFFF, 1'b1, 1'b0, 11'd2, 1'b1, 32'h1, 32'h1),
            make_row(1'b0, 32'h7FFF_FFFF, 1'b0, 1'b0, 11'd0, 1'b0, 32'h0, 32'h0),
            make_row(1'b0, 32'h8000_0000, 1'b0, 1'b0, 11'd0, 1'b0, 32'h0, 32'h0),
            make_row(1'b0, 32'h0000_1000, 1'b0, 1'b0, 11'd0, 1'b0, 32'h0, 32'h0),
            make_row(1'b0, 32'h0000_0FFF, 1'b0, 1'b0, 11'd0, 1'b0, 32'h0, 32'h0),
            make_row(1'b0, 32'hAAAA_AAAA, 1'b0, 1'b0, 11'd0, 1'b0, 32'h0, 32'h0),
            make_row(1'b0, 32'h5555_5555, 1'b0, 1'b0, 11'd0, 1'b0, 32'h0, 32'h0),
            make_row(1'b0, 32'hFFFF_FFFE, 1'b0, 1'b0, 11'd0, 1'b0, 32'h0, 32'h0),
            // tenth value fills the set
            make_row(1'b0, 32'h7FFF_FFFE, 1'b0, 1'b0, 11'd0, 1'b0, 32'h0, 32'h0),
            // full set drops these
            make_row(1'b0, 32'h1234_5678, 1'b0, 1'b0, 11'd0, 1'b0, 32'h0, 32'h0),
            make_row(1'b0, 32'h0000_0000, 1'b0, 1'b0, 11'd0, 1'b0, 32'h0, 32'h0),
            // restart on a full set, then the two extremes: both spans all ones
            make_row(1'b1, 32'h8000_0000, 1'b1, 1'b0, 11'd1, 1'b0, 32'h0, 32'h0),
            make_row(1'b0, 32'h7FFF_FFFF, 1'b1, 1'b0, 11'd2, 1'b1, 32'hFFFF_FFFF,
                     32'hFFFF_FFFF),
            make_row(1'b0, 32'h0000_0000, 1'b0, 1'b0, 11'd0, 1'b0, 32'h0, 32'h0),
            // back-to-back restarts
            make_row(1'b1, 32'h0000_0001, 1'b1, 1'b0, 11'd1, 1'b0, 32'h0, 32'h0),
            make_row(1'b1, 32'h0000_0002, 1'b1, 1'b0, 11'd1, 1'b0, 32'h0, 32'h0),
            make_row(1'b0, 32'h0000_0002, 1'b1, 1'b0, 11'd2, 1'b1, 32'h0, 32'h0)
        };

        // synchronous reset, released on a falling clock edge
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        empty_set();
        size_limit = MAX_SIZE_RESET;

        ready_pattern = 16'hD7B5;
        for (int k = 0; k < DIRECTED_N; k++) begin
            pace_sender(3);
            send_word(directed_rows[k].restart, directed_rows[k].value,
                      directed_rows[k].typed, directed_rows[k].want);
        end

        // random phases over the register range
        run_phase(11'd0,    20,  4,  0, 3, 16'hFFFF);   // every value dropped
        run_phase(11'd1,    25,  5,  0, 5, 16'hB6DB);   // never two values held
        run_phase(11'd2,    30,  6,  0, 0, 16'hFFFF);   // no idling on either side
        run_phase(11'd2047, 140, 20, 48, 6, 16'($urandom)); // above capacity
        run_phase(11'd1024, 100, 15, 64, 2, 16'($urandom)); // exactly capacity
        run_phase(11'($urandom_range(3, 40)), 120, 30, 0, 4, 16'($urandom));

        // limit lowered below the held count: drops until a restart
        run_phase(11'd1024, 1,  1, 0, 2, 16'($urandom));
        run_phase(11'd1024, 12, 0, 0, 2, 16'($urandom));
        run_phase(11'd4,    15, 0, 0, 3, 16'($urandom));
        run_phase(11'd4,    20, 6, 0, 3, 16'($urandom));

        run_phase(11'd10,   100, 12, 0, 3, 16'($urandom)); // back to the reset limit

        // drain, then watch a while longer for stray result words
        drop_valid();
        while (pending_reports.size() != 0) @(negedge i_clk);
        repeat (200) @(posedge i_clk);

        $display("sent %0d words under limits 0, 1, 2, 4, 10, 1024, 2047 and one random,",
                 words_sent);
        $display("checked %0d results, %0d drops on a full set, largest set %0d values",
                 words_checked, drops_seen, largest_count);
        if (mismatch_count == 0 && pending_reports.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    // watchdog, several times the slowest legal run
    initial begin
        #2_000_000;
        $display("timeout with %0d results outstanding", pending_reports.size());
        $display("TEST FAILED");
        $finish;
    end

endmodule
